[rtl/kwm_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// kwm_pkg
// Shared types and constants of the k-way merge minimum cost unit.
// ----------------------------------------------------------------------------
package kwm_pkg;

    localparam int MAX_STONES_DEF = 32;
    localparam int MAX_ARITY_DEF  = 8;

    localparam int WEIGHT_W = 16;
    localparam int COST_W   = 32;
    localparam int ARITY_W  = 4;

    localparam logic [COST_W-1:0]  COST_INF    = '1;
    localparam logic [ARITY_W-1:0] ARITY_RESET = ARITY_W'(2);

    typedef struct packed {
        logic [WEIGHT_W-1:0] stone_weight;
        logic                last;
    } in_item_t;

    typedef struct packed {
        logic [COST_W-1:0] min_cost;
        logic              possible;
        logic              overflow;
    } out_item_t;

    // source of the value written into the cost table
    typedef enum logic [1:0] {
        CW_ZERO,
        CW_INF,
        CW_BEST,
        CW_COLLAPSE
    } cw_sel_t;

    // kind of result loaded into the output register
    typedef enum logic [1:0] {
        RES_TABLE,
        RES_ZERO,
        RES_IMPOSS,
        RES_OVF
    } res_sel_t;

    typedef struct packed {
        logic     pw_en;      // write running sum into prefix memory
        logic     run_clr;    // start a new row
        logic     cw_en;      // write cost table
        cw_sel_t  cw_sel;
        logic     acc_en;     // compare read pair in the next cycle
        logic     best_init;
        logic     best_load;
        logic     lo_zero;    // lower prefix bound is entry zero
        logic     sum_cap;    // capture group cost and range weight
        logic     out_load;
        res_sel_t res_sel;
    } cmd_t;

    typedef struct packed {
        logic out_busy;
    } stat_t;

endpackage
`default_nettype wire

[rtl/kwm_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// kwm_ram
// Generic RAM: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module kwm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr_a,
    output logic      [WIDTH-1:0] rd_data_a,
    input  wire logic [AW-1:0]    rd_addr_b,
    output logic      [WIDTH-1:0] rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule
`default_nettype wire

[rtl/kwm_dpath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// kwm_dpath
// Datapath: prefix sum and cost memories, saturating adders, min tracking
// and the output register.
// ----------------------------------------------------------------------------
module kwm_dpath #(
    parameter int MAX_STONES = kwm_pkg::MAX_STONES_DEF,
    parameter int MAX_ARITY  = kwm_pkg::MAX_ARITY_DEF,
    localparam int IW = (MAX_STONES > 1) ? $clog2(MAX_STONES) : 1,
    localparam int GW = $clog2(MAX_ARITY + 1),
    localparam int AW = 2 * IW + GW
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire kwm_pkg::cmd_t                cmd,
    output kwm_pkg::stat_t                    stat,
    input  wire logic [kwm_pkg::WEIGHT_W-1:0] weight,
    input  wire logic [AW-1:0]                ca_addr,
    input  wire logic [AW-1:0]                cb_addr,
    input  wire logic [AW-1:0]                cw_addr,
    input  wire logic [IW-1:0]                pa_addr,
    input  wire logic [IW-1:0]                pb_addr,
    input  wire logic [IW-1:0]                pw_addr,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output kwm_pkg::out_item_t                m_data
);

    localparam int PW = kwm_pkg::WEIGHT_W + $clog2(MAX_STONES + 1);
    localparam int CWD = kwm_pkg::COST_W;

    logic [PW-1:0]  run_reg, run_next;
    logic [PW-1:0]  pa_data, pb_data;
    logic [CWD-1:0] ca_data, cb_data, cw_data;
    logic [CWD-1:0] best_reg, best_next;
    logic [CWD-1:0] kc_reg;
    logic [PW-1:0]  wsum_reg;
    logic           acc_reg, lo_zero_reg;
    logic           m_valid_reg;
    kwm_pkg::out_item_t out_reg, out_next;

    logic [CWD:0]   pair_sum, col_sum;
    logic [CWD-1:0] pair_sat, col_val;
    logic           pair_take;
    logic           best_fin;

    assign run_next = run_reg + PW'(weight);

    kwm_ram #(.WIDTH(PW), .DEPTH(MAX_STONES)) u_prefix_ram (
        .aclk     (aclk),
        .wr_en    (cmd.pw_en),
        .wr_addr  (pw_addr),
        .wr_data  (run_next),
        .rd_addr_a(pa_addr),
        .rd_data_a(pa_data),
        .rd_addr_b(pb_addr),
        .rd_data_b(pb_data)
    );

    kwm_ram #(.WIDTH(CWD), .DEPTH(2 ** AW)) u_cost_ram (
        .aclk     (aclk),
        .wr_en    (cmd.cw_en),
        .wr_addr  (cw_addr),
        .wr_data  (cw_data),
        .rd_addr_a(ca_addr),
        .rd_data_a(ca_data),
        .rd_addr_b(cb_addr),
        .rd_data_b(cb_data)
    );

    // candidate split: first group plus remaining groups
    always_comb begin
        pair_sum  = {1'b0, ca_data} + {1'b0, cb_data};
        pair_sat  = pair_sum[CWD] ? kwm_pkg::COST_INF : pair_sum[CWD-1:0];
        pair_take = (ca_data != kwm_pkg::COST_INF) && (cb_data != kwm_pkg::COST_INF)
                    && (pair_sat < best_reg);
    end

    // collapse a range into one group
    always_comb begin
        col_sum = {1'b0, kc_reg} + (CWD + 1)'(wsum_reg);
        if (kc_reg == kwm_pkg::COST_INF || col_sum[CWD]) begin
            col_val = kwm_pkg::COST_INF;
        end else begin
            col_val = col_sum[CWD-1:0];
        end
    end

    always_comb begin
        case (cmd.cw_sel)
            kwm_pkg::CW_ZERO:     cw_data = '0;
            kwm_pkg::CW_INF:      cw_data = kwm_pkg::COST_INF;
            kwm_pkg::CW_BEST:     cw_data = best_reg;
            kwm_pkg::CW_COLLAPSE: cw_data = col_val;
            default:              cw_data = kwm_pkg::COST_INF;
        endcase
    end

    always_comb begin
        best_next = best_reg;
        if (cmd.best_init) begin
            best_next = kwm_pkg::COST_INF;
        end else if (cmd.best_load) begin
            best_next = ca_data;
        end else if (acc_reg && pair_take) begin
            best_next = pair_sat;
        end
    end

    assign best_fin = (best_reg != kwm_pkg::COST_INF);

    always_comb begin
        out_next = '0;
        case (cmd.res_sel)
            kwm_pkg::RES_TABLE: begin
                out_next.min_cost = best_fin ? best_reg : '0;
                out_next.possible = best_fin;
            end
            kwm_pkg::RES_ZERO:   out_next.possible = 1'b1;
            kwm_pkg::RES_IMPOSS: out_next.possible = 1'b0;
            kwm_pkg::RES_OVF:    out_next.overflow = 1'b1;
            default:             out_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg     <= '0;
            acc_reg     <= 1'b0;
            lo_zero_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            acc_reg     <= cmd.acc_en;
            lo_zero_reg <= cmd.lo_zero;
            if (cmd.run_clr) begin
                run_reg <= '0;
            end else if (cmd.pw_en) begin
                run_reg <= run_next;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        best_reg <= best_next;
        if (cmd.sum_cap) begin
            kc_reg   <= ca_data;
            wsum_reg <= pa_data - (lo_zero_reg ? PW'(0) : pb_data);
        end
        if (cmd.out_load) begin
            out_reg <= out_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_data        = out_reg;
    assign stat.out_busy = m_valid_reg && !m_ready;

endmodule
`default_nettype wire

[rtl/kwm_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// kwm_ctrl
// Controller: row loading, interval table sweep and result sequencing.
// ----------------------------------------------------------------------------
module kwm_ctrl #(
    parameter int MAX_STONES = kwm_pkg::MAX_STONES_DEF,
    parameter int MAX_ARITY  = kwm_pkg::MAX_ARITY_DEF,
    localparam int IW = (MAX_STONES > 1) ? $clog2(MAX_STONES) : 1,
    localparam int GW = $clog2(MAX_ARITY + 1),
    localparam int AW = 2 * IW + GW
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic                        s_last,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [kwm_pkg::ARITY_W-1:0] cfg_data,
    output kwm_pkg::cmd_t                    cmd,
    input  wire kwm_pkg::stat_t              stat,
    output logic [AW-1:0]                    ca_addr,
    output logic [AW-1:0]                    cb_addr,
    output logic [AW-1:0]                    cw_addr,
    output logic [IW-1:0]                    pa_addr,
    output logic [IW-1:0]                    pb_addr,
    output logic [IW-1:0]                    pw_addr
);

    localparam int CW = $clog2(MAX_STONES + 2);

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_INIT,
        S_MLOOP,
        S_ACC,
        S_WRB,
        S_COL_RD,
        S_COL_SUM,
        S_COL_WR,
        S_FIN_RD,
        S_FIN_CAP,
        S_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic [kwm_pkg::ARITY_W-1:0] k_reg, k_next;
    logic [CW-1:0] pc_reg, pc_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] len_reg, len_next;
    logic [IW-1:0] i_reg, i_next;
    logic [IW-1:0] j_reg, j_next;
    logic [IW-1:0] m_reg, m_next;
    logic [GW-1:0] g_reg, g_next;
    kwm_pkg::res_sel_t res_reg, res_next;

    logic          s_acc;
    logic          arity_ok;
    logic [GW-1:0] k_g;
    logic [IW-1:0] n_last;
    logic [CW-1:0] pc_inc;

    assign s_acc     = s_valid && s_ready;
    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign arity_ok  = (32'(k_reg) >= 32'd2) && (32'(k_reg) <= 32'(MAX_ARITY));
    assign k_g       = GW'(k_reg);
    assign n_last    = IW'(n_reg - CW'(1));
    assign pc_inc    = (pc_reg < CW'(MAX_STONES)) ? pc_reg + CW'(1) : CW'(MAX_STONES + 1);

    always_comb begin
        state_next = state_reg;
        k_next     = k_reg;
        pc_next    = pc_reg;
        n_next     = n_reg;
        len_next   = len_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        m_next     = m_reg;
        g_next     = g_reg;
        res_next   = res_reg;
        cmd        = '0;
        cmd.cw_sel  = kwm_pkg::CW_ZERO;
        cmd.res_sel = res_reg;
        ca_addr = {i_reg, m_reg, GW'(1)};
        cb_addr = {m_reg + IW'(1), j_reg, g_reg - GW'(1)};
        cw_addr = {i_reg, j_reg, g_reg};
        pa_addr = j_reg;
        pb_addr = i_reg - IW'(1);
        pw_addr = pc_reg[IW-1:0];

        if (cfg_valid) begin
            k_next = cfg_data;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    cmd.pw_en = (pc_reg < CW'(MAX_STONES));
                    pc_next   = pc_inc;
                    if (s_last) begin
                        n_next     = pc_inc;
                        pc_next    = '0;
                        state_next = S_START;
                    end
                end
            end
            S_START: begin
                cmd.run_clr    = 1'b1;
                cmd.best_init  = 1'b1;
                state_next     = S_EMIT;
                if (n_reg == CW'(MAX_STONES + 1)) begin
                    res_next = kwm_pkg::RES_OVF;
                end else if (n_reg == CW'(1)) begin
                    res_next = kwm_pkg::RES_ZERO;
                end else if (!arity_ok) begin
                    res_next = kwm_pkg::RES_IMPOSS;
                end else begin
                    res_next   = kwm_pkg::RES_TABLE;
                    i_next     = '0;
                    g_next     = GW'(1);
                    state_next = S_INIT;
                end
            end
            S_INIT: begin
                // single piles: zero as one group, impossible as more
                cmd.best_init = 1'b1;
                cmd.cw_en     = 1'b1;
                cmd.cw_sel    = (g_reg == GW'(1)) ? kwm_pkg::CW_ZERO : kwm_pkg::CW_INF;
                cw_addr       = {i_reg, i_reg, g_reg};
                if (g_reg == k_g) begin
                    g_next = GW'(1);
                    if (i_reg == n_last) begin
                        len_next   = CW'(2);
                        i_next     = '0;
                        j_next     = IW'(1);
                        m_next     = '0;
                        g_next     = GW'(2);
                        state_next = S_MLOOP;
                    end else begin
                        i_next = i_reg + IW'(1);
                    end
                end else begin
                    g_next = g_reg + GW'(1);
                end
            end
            S_MLOOP: begin
                cmd.acc_en = 1'b1;
                if (m_reg == j_reg - IW'(1)) begin
                    state_next = S_ACC;
                end else begin
                    m_next = m_reg + IW'(1);
                end
            end
            S_ACC: begin
                state_next = S_WRB;
            end
            S_WRB: begin
                cmd.cw_en     = 1'b1;
                cmd.cw_sel    = kwm_pkg::CW_BEST;
                cmd.best_init = 1'b1;
                if (g_reg == k_g) begin
                    state_next = S_COL_RD;
                end else begin
                    g_next     = g_reg + GW'(1);
                    m_next     = i_reg;
                    state_next = S_MLOOP;
                end
            end
            S_COL_RD: begin
                ca_addr     = {i_reg, j_reg, k_g};
                cmd.lo_zero = (i_reg == '0);
                state_next  = S_COL_SUM;
            end
            S_COL_SUM: begin
                cmd.sum_cap = 1'b1;
                state_next  = S_COL_WR;
            end
            S_COL_WR: begin
                cmd.cw_en  = 1'b1;
                cmd.cw_sel = kwm_pkg::CW_COLLAPSE;
                cw_addr    = {i_reg, j_reg, GW'(1)};
                g_next     = GW'(2);
                state_next = S_MLOOP;
                if (j_reg != n_last) begin
                    i_next = i_reg + IW'(1);
                    j_next = j_reg + IW'(1);
                    m_next = i_reg + IW'(1);
                end else if (i_reg == '0) begin
                    state_next = S_FIN_RD;
                end else begin
                    // advance to the next range length
                    len_next = len_reg + CW'(1);
                    i_next   = '0;
                    j_next   = IW'(len_reg);
                    m_next   = '0;
                end
            end
            S_FIN_RD: begin
                ca_addr    = {IW'(0), n_last, GW'(1)};
                state_next = S_FIN_CAP;
            end
            S_FIN_CAP: begin
                cmd.best_load = 1'b1;
                state_next    = S_EMIT;
            end
            S_EMIT: begin
                // hold until the output register is free
                if (!stat.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            k_reg     <= kwm_pkg::ARITY_RESET;
            pc_reg    <= '0;
            n_reg     <= '0;
            res_reg   <= kwm_pkg::RES_ZERO;
        end else begin
            state_reg <= state_next;
            k_reg     <= k_next;
            pc_reg    <= pc_next;
            n_reg     <= n_next;
            res_reg   <= res_next;
        end
        len_reg <= len_next;
        i_reg   <= i_next;
        j_reg   <= j_next;
        m_reg   <= m_next;
        g_reg   <= g_next;
    end

endmodule
`default_nettype wire

[rtl/k_way_merge_min_cost_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// k_way_merge_min_cost_unit
// Least cost of merging a row of piles K at a time, by interval table fill.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one request per pile (weight, last flag).
//   cfg channel: merge arity K, always ready; write only while idle.
//   m_ channel: one result per row, after the request marked last.
// Table fill runs for arity K in 2..MAX_ARITY; the two-port cost memory
// yields one split candidate per cycle. Single piles, overflowed rows
// and an illegal arity skip the table fill and go straight to the result.
// Piles are taken in consecutive cycles while loading; s_ready drops from
// the last pile until the result is loaded into the output register.
// The next row may load while that result waits on a stalled receiver;
// its result is held until the register frees up.
// Reset (aresetn low, synchronous) empties the row, drops any pending
// result and sets the arity to 2. No memory clearing pass is needed.
// ----------------------------------------------------------------------------
module k_way_merge_min_cost_unit #(
    parameter int MAX_STONES = kwm_pkg::MAX_STONES_DEF,
    parameter int MAX_ARITY  = kwm_pkg::MAX_ARITY_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire kwm_pkg::in_item_t           s_data,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output kwm_pkg::out_item_t               m_data,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [kwm_pkg::ARITY_W-1:0] cfg_data
);

    localparam int IW = (MAX_STONES > 1) ? $clog2(MAX_STONES) : 1;
    localparam int GW = $clog2(MAX_ARITY + 1);
    localparam int AW = 2 * IW + GW;

    kwm_pkg::cmd_t  cmd;
    kwm_pkg::stat_t stat;
    logic [AW-1:0]  ca_addr, cb_addr, cw_addr;
    logic [IW-1:0]  pa_addr, pb_addr, pw_addr;

    kwm_ctrl #(.MAX_STONES(MAX_STONES), .MAX_ARITY(MAX_ARITY)) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_last   (s_data.last),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .stat     (stat),
        .ca_addr  (ca_addr),
        .cb_addr  (cb_addr),
        .cw_addr  (cw_addr),
        .pa_addr  (pa_addr),
        .pb_addr  (pb_addr),
        .pw_addr  (pw_addr)
    );

    kwm_dpath #(.MAX_STONES(MAX_STONES), .MAX_ARITY(MAX_ARITY)) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .stat    (stat),
        .weight  (s_data.stone_weight),
        .ca_addr (ca_addr),
        .cb_addr (cb_addr),
        .cw_addr (cw_addr),
        .pa_addr (pa_addr),
        .pb_addr (pb_addr),
        .pw_addr (pw_addr),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
`default_nettype wire

[test/k_way_merge_min_cost_unit_tb.sv]
// ----------------------------------------------------------------------------
// k_way_merge_min_cost_unit_tb
// Drives rows of pile weights under several merge arities and compares each
// row's merge cost, possible and overflow flags against an interval-table
// predictor. Both channels idle at random; the receiver also stalls long.
// ----------------------------------------------------------------------------
module k_way_merge_min_cost_unit_tb;

    localparam int NMAX      = 32;
    localparam int AMAX      = 8;
    localparam int STALL_MAX = 400000;

    logic                         aclk = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         s_valid = 1'b0;
    logic                         s_ready;
    kwm_pkg::in_item_t            s_data = '0;
    logic                         m_valid;
    logic                         m_ready = 1'b0;
    kwm_pkg::out_item_t           m_data;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [kwm_pkg::ARITY_W-1:0]  cfg_data = '0;

    k_way_merge_min_cost_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #2 aclk = ~aclk;

    // predictor state
    logic [kwm_pkg::ARITY_W-1:0] arity_q = kwm_pkg::ARITY_RESET;
    logic [31:0]                 row_sums[0:NMAX];
    int                          row_len = 0;
    kwm_pkg::out_item_t          cost_q[$];

    int  fail_cnt = 0;
    bit  quiet_mode = 0;   // no random idling
    bit  rx_hold = 0;
    int  stall_cycles = 0;

    function automatic logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? kwm_pkg::COST_INF : s[31:0];
    endfunction

    function automatic logic [31:0] merge_cost(int n, int k);
        logic [31:0] tab[0:NMAX-1][0:NMAX-1][0:AMAX];
        logic [31:0] best, a, b, s, kc;
        int j;
        for (int i = 0; i < n; i++) begin
            tab[i][i][1] = 0;
            for (int g = 2; g <= k; g++) tab[i][i][g] = kwm_pkg::COST_INF;
        end
        for (int len = 2; len <= n; len++) begin
            for (int i = 0; i + len - 1 < n; i++) begin
                j = i + len - 1;
                for (int g = 2; g <= k; g++) begin
                    best = kwm_pkg::COST_INF;
                    for (int m = i; m < j; m++) begin
                        a = tab[i][m][1];
                        b = tab[m+1][j][g-1];
                        if (a != kwm_pkg::COST_INF && b != kwm_pkg::COST_INF) begin
                            s = sat_sum(a, b);
                            if (s < best) best = s;
                        end
                    end
                    tab[i][j][g] = best;
                end
                kc = tab[i][j][k];
                tab[i][j][1] = (kc == kwm_pkg::COST_INF) ? kwm_pkg::COST_INF
                    : sat_sum(kc, row_sums[j+1] - row_sums[i]);
            end
        end
        return tab[0][n-1][1];
    endfunction

    function automatic void predict_pile(kwm_pkg::in_item_t it);
        kwm_pkg::out_item_t r;
        logic [31:0] c;
        int n;
        if (row_len < NMAX) begin
            row_sums[row_len+1] = row_sums[row_len] + it.stone_weight;
            row_len++;
        end else begin
            row_len = NMAX + 1;
        end
        if (!it.last) return;
        n = row_len;
        row_len = 0;
        r = '0;
        if (n > NMAX) begin
            r.overflow = 1'b1;
        end else begin
            if (n == 1) c = 0;
            else if (arity_q < 2 || arity_q > AMAX) c = kwm_pkg::COST_INF;
            else c = merge_cost(n, arity_q);
            if (c != kwm_pkg::COST_INF) begin
                r.min_cost = c;
                r.possible = 1'b1;
            end
        end
        cost_q.push_back(r);
    endfunction

    initial row_sums[0] = 0;

    // valid stays high after acceptance; drop it before idling
    task automatic send_pile(logic [15:0] w, logic lst);
        while (!quiet_mode && $urandom_range(99) < 20) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{stone_weight: w, last: lst};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_pile('{stone_weight: w, last: lst});
    endtask

    task automatic drain_results();
        while (cost_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_arity(logic [kwm_pkg::ARITY_W-1:0] k);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= k;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        arity_q = k;
    endtask

    task automatic send_row(int n, int wmode);
        logic [15:0] w;
        for (int i = 0; i < n; i++) begin
            case (wmode)
                0: w = 16'($urandom);
                1: w = 16'hFFFF;
                2: w = 16'h0000;
                default: w = 16'($urandom_range(9));
            endcase
            send_pile(w, i == n - 1);
        end
        // drop the accepted last request
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // pick a length that usually merges cleanly for arity k
    function automatic int pick_len(int k);
        int kk, t;
        if ($urandom_range(3) == 0) return $urandom_range(1, 10);
        kk = (k < 2 || k > AMAX) ? 2 : k;
        t = $urandom_range(0, (kk == 2) ? 8 : 3);
        return 1 + t * (kk - 1);
    endfunction

    task automatic test_directed();
        send_row(1, 0);
        send_row(1, 1);
        send_row(2, 1);
        send_row(2, 2);
        send_row(3, 1);
        send_row(5, 3);
        write_arity(3);
        send_row(2, 3);
        send_row(3, 0);
        send_row(7, 1);
        write_arity(0);
        send_row(2, 0);
        send_row(1, 0);
        write_arity(15);
        send_row(3, 0);
    endtask

    task automatic test_overflow();
        write_arity(2);
        send_row(NMAX, 0);
        send_row(NMAX + 1, 0);
        send_row(NMAX + 5, 1);
        send_row(3, 0);
    endtask

    task automatic test_random(int items);
        int sent, n, mode;
        logic [kwm_pkg::ARITY_W-1:0] ks[8] = '{2, 3, 4, 8, 5, 9, 1, 7};
        sent = 0;
        for (int ph = 0; ph < 8; ph++) begin
            write_arity(ks[ph]);
            quiet_mode = (ph == 3);
            while (sent < (ph + 1) * items / 8) begin
                n = pick_len(ks[ph]);
                mode = $urandom_range(3);
                send_row(n, mode);
                sent += n;
            end
        end
        quiet_mode = 0;
    endtask

    task automatic test_back_pressure();
        write_arity(2);
        rx_hold = 1;
        for (int r = 0; r < 6; r++) send_row($urandom_range(1, 4), 0);
        rx_hold = 0;
        drain_results();
        send_row(NMAX, 1);
    endtask

    // receiver: random idling, plus a long hold counted here
    always @(posedge aclk) begin
        if (rx_hold && stall_cycles < 300) begin
            stall_cycles <= stall_cycles + 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= quiet_mode ? 1'b1 : ($urandom_range(99) >= 20);
        end
    end

    // result checker
    always @(posedge aclk) begin
        kwm_pkg::out_item_t e;
        if (aresetn && m_valid && m_ready) begin
            if (cost_q.size() == 0) begin
                $error("result with none expected: %h", m_data);
                fail_cnt++;
            end else begin
                e = cost_q.pop_front();
                if (m_data.min_cost !== e.min_cost) begin
                    $error("min_cost exp %0d got %0d", e.min_cost, m_data.min_cost);
                    fail_cnt++;
                end
                if (m_data.possible !== e.possible) begin
                    $error("possible exp %0b got %0b", e.possible, m_data.possible);
                    fail_cnt++;
                end
                if (m_data.overflow !== e.overflow) begin
                    $error("overflow exp %0b got %0b", e.overflow, m_data.overflow);
                    fail_cnt++;
                end
            end
        end
    end

    // watchdog on cycles with no request moving
    int idle_cycles = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_MAX) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_overflow();
        test_back_pressure();
        test_random(1550);
        drain_results();
        if (fail_cnt == 0 && cost_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

[k_way_merge_min_cost_unit.f]
rtl/kwm_pkg.sv
rtl/kwm_ram.sv
rtl/kwm_dpath.sv
rtl/kwm_ctrl.sv
rtl/k_way_merge_min_cost_unit.sv
test/k_way_merge_min_cost_unit_tb.sv
